/* hdl/uuidp_pkg.sv */
// uuid text parser: shared constants, types and the hex digit decoder
// no dependencies; used by every file of the block
package uuidp_pkg;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_NO_DASH   = 2'd2;
    localparam logic [1:0] ST_BAD_CLOSE = 2'd3;

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_CLOSE  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DASH   = 8'h2D;

    localparam logic [4:0] CNT_DASH_FIRST = 5'd8;
    localparam logic [4:0] CNT_LAST       = 5'd31;

    typedef struct packed {
        logic        emit;
        logic [1:0]  status;
        logic [63:0] uuid_high;
        logic [63:0] uuid_low;
    } t_result;

    // bit 4 set marks a character that is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

/* hdl/uuidp_step.sv */
// uuid text parser: per-character state update and result decision
// depends on uuidp_pkg
module uuidp_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_character,
    input  logic              i_last,
    output uuidp_pkg::t_result o_result
);

    logic [1:0]   r_phase, n_phase;
    logic [4:0]   r_count, n_count;
    logic         r_brace, n_brace;
    logic         r_dash, n_dash;
    logic         r_sep, n_sep;
    logic [127:0] r_value, n_value;

    logic         emit;
    logic [1:0]   status;
    logic [4:0]   hv;
    logic [127:0] shifted;

    always_comb begin
        hv      = uuidp_pkg::hex_value(i_character);
        shifted = {r_value[123:0], (hv[4] ? 4'hF : hv[3:0])};
        if (r_count[0] && hv[4]) begin
            shifted[7:0] = 8'hFF;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_brace = r_brace;
        n_dash  = r_dash;
        n_sep   = r_sep;
        n_value = r_value;
        emit    = 1'b0;
        status  = uuidp_pkg::ST_OK;
        case (r_phase)
            uuidp_pkg::PH_START, uuidp_pkg::PH_DIGITS: begin
                n_phase = uuidp_pkg::PH_DIGITS;
                if (r_phase == uuidp_pkg::PH_START && i_character == uuidp_pkg::CH_LBRACE) begin
                    n_brace = 1'b1;
                end else if (!r_sep && r_count == uuidp_pkg::CNT_DASH_FIRST
                             && i_character == uuidp_pkg::CH_DASH) begin
                    n_dash = 1'b1;
                    n_sep  = 1'b1;
                end else if (!r_sep && r_dash
                             && (r_count inside {5'd12, 5'd16, 5'd20})) begin
                    if (i_character == uuidp_pkg::CH_DASH) begin
                        n_sep = 1'b1;
                    end else begin
                        n_phase = uuidp_pkg::PH_DONE;
                        emit    = 1'b1;
                        status  = uuidp_pkg::ST_NO_DASH;
                    end
                end else begin
                    n_value = shifted;
                    n_sep   = 1'b0;
                    if (r_count == uuidp_pkg::CNT_LAST) begin
                        n_count = '0;
                        if (r_brace) begin
                            n_phase = uuidp_pkg::PH_CLOSE;
                        end else begin
                            n_phase = uuidp_pkg::PH_DONE;
                            emit    = 1'b1;
                            status  = uuidp_pkg::ST_OK;
                        end
                    end else begin
                        n_count = r_count + 5'd1;
                    end
                end
            end
            uuidp_pkg::PH_CLOSE: begin
                n_phase = uuidp_pkg::PH_DONE;
                emit    = 1'b1;
                status  = (i_character == uuidp_pkg::CH_RBRACE) ? uuidp_pkg::ST_OK
                                                                 : uuidp_pkg::ST_BAD_CLOSE;
            end
            default: begin
            end
        endcase
        if (!emit && i_last && r_phase != uuidp_pkg::PH_DONE) begin
            emit   = 1'b1;
            status = uuidp_pkg::ST_SHORT;
        end
        o_result.emit      = emit;
        o_result.status    = status;
        o_result.uuid_high = (status == uuidp_pkg::ST_OK) ? n_value[127:64] : 64'd0;
        o_result.uuid_low  = (status == uuidp_pkg::ST_OK) ? n_value[63:0]   : 64'd0;
        if (i_last) begin
            n_phase = uuidp_pkg::PH_START;
            n_count = '0;
            n_brace = 1'b0;
            n_dash  = 1'b0;
            n_sep   = 1'b0;
            n_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= uuidp_pkg::PH_START;
            r_count <= '0;
            r_brace <= 1'b0;
            r_dash  <= 1'b0;
            r_sep   <= 1'b0;
            r_value <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_brace <= n_brace;
            r_dash  <= n_dash;
            r_sep   <= n_sep;
            r_value <= n_value;
        end
    end

endmodule

/* hdl/uuid_text_parser_top.sv */
// uuid text parser top level: input register, step logic and result register
// depends on uuidp_pkg and uuidp_step
//
//  channel | handshake                | payload
//  --------+--------------------------+----------------------------------
//  input   | i_in_valid / o_in_ready  | i_character, i_last
//  output  | o_out_valid / i_out_ready| o_uuid_high, o_uuid_low, o_status
//
// one character per cycle while no stalled result holds the step; an accepted
// request passes the input register, then its result the result register
// reset clears all parse state and both valid flags; no clearing pass
// a stalled result holds the step, even for a character that gives no result;
// the input register then keeps one request and the input stalls
module uuid_text_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_character,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_uuid_high,
    output logic [63:0] o_uuid_low,
    output logic [1:0]  o_status
);

    logic        r_in_valid;
    logic [7:0]  r_character;
    logic        r_last;
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [63:0] r_high;
    logic [63:0] r_low;

    logic              adv;
    uuidp_pkg::t_result result;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    uuidp_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (adv),
        .i_character (r_character),
        .i_last      (r_last),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_character <= i_character;
            r_last      <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && result.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && result.emit) begin
            r_status <= result.status;
            r_high   <= result.uuid_high;
            r_low    <= result.uuid_low;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_uuid_high = r_high;
    assign o_uuid_low  = r_low;

endmodule

/* hdl/uuidp_checker.sv */
// uuid text parser: port-level checks and their bind to the top level
// depends on uuidp_pkg
module uuidp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_uuid_high,
    input logic [63:0] o_uuid_low,
    input logic [1:0]  o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_status) && $stable(o_uuid_high) && $stable(o_uuid_low))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != uuidp_pkg::ST_OK |->
            o_uuid_high == 64'd0 && o_uuid_low == 64'd0)
        else $error("error result carries uuid bits");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

endmodule

bind uuid_text_parser_top uuidp_checker u_uuidp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_uuid_high (o_uuid_high),
    .o_uuid_low  (o_uuid_low),
    .o_status    (o_status)
);
